### src/ccfd_pkg.sv
package ccfd_pkg;

    localparam int BUF_BYTES  = 256;
    localparam int ADDR_W     = $clog2(BUF_BYTES);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int HDR_LEN    = 5;
    localparam int TRL_LEN    = 2;
    localparam int RES_SLOTS  = 64;
    localparam int OUT_DATA_W = 200;

    localparam logic [7:0]  CHECK_XOR = 8'h5A;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_MSB   = 16'h8000;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam logic KIND_CHUNK  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] max_payload;
    } t_cfg;

    // One byte of CRC-16/CCITT-FALSE, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/crc_checked_frame_deframer_core.sv
// A push that completes no frame still gives a status item; header reads are added
// when at least five bytes are buffered. After a dropped byte the header is checked
// again, then come the CRC pass and the chunks: one buffer RAM read port serves all of it.
// A new push is taken only once the last one's status item is issued; a two-entry
// input queue absorbs short bursts.
// Reset (i_rst_n low, synchronous) empties the buffer, clears counters, restores config.
module crc_checked_frame_deframer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] chunk_bytes, [67:4] payload_chunk, [68] frame_end, [69] buffer_status,
    // [101:70] frames_delivered, [133:102] resync_count, [165:134] bad_length_count,
    // [197:166] bad_crc_count, [199:198] zero
    output logic [199:0] m_axis_tdata,
    output logic         m_axis_tuser,   // [0] item_kind
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    ccfd_pkg::t_cfg  r_cfg;
    ccfd_pkg::t_item item;
    logic            item_valid;
    logic            item_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= 8'hAA;
            r_cfg.sync_second <= 8'h55;
            r_cfg.max_payload <= 8'd192;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ccfd_pkg::REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                ccfd_pkg::REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                ccfd_pkg::REG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ccfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    ccfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_kind       (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("tlast does not match status kind");

    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[3:0] <= 4'd8))
        else $error("chunk larger than eight bytes");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[68:0] == 69'd0))
        else $error("status item carries payload fields");

endmodule

### src/ccfd_ram.sv
module ccfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ccfd_front.sv
module ccfd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [7:0]           i_data,
    output logic                 o_item_valid,
    input  logic                 i_item_ready,
    output ccfd_pkg::t_item      o_item
);

    // Two-entry queue between the link side and the frame engine.
    ccfd_pkg::t_item r_q [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;
    ccfd_pkg::t_item in_item;

    assign o_ready      = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rptr];
    assign push         = i_valid && o_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_comb begin
        in_item.op = (i_op == ccfd_pkg::OP_RESET) ? ccfd_pkg::OP_RESET : ccfd_pkg::OP_PUSH;
        // A reset transaction carries no byte.
        in_item.data = (i_op == ccfd_pkg::OP_RESET) ? 8'h00 : i_data;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

### src/ccfd_back.sv
module ccfd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ccfd_pkg::t_cfg                      i_cfg,
    input  logic                                i_item_valid,
    output logic                                o_item_ready,
    input  ccfd_pkg::t_item                     i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ccfd_pkg::OUT_DATA_W-1:0]     o_data,
    output logic                                o_kind,
    output logic                                o_last
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_HDR  = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_CRC  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_STAT = 4'd8;

    localparam int AW = ccfd_pkg::ADDR_W;
    localparam int FW = ccfd_pkg::FILL_W;

    logic [3:0]      r_st;
    logic            r_wait;
    logic [FW-1:0]   r_idx;
    logic [AW-1:0]   r_head;
    logic [FW-1:0]   r_fill;
    logic [7:0]      r_h [ccfd_pkg::HDR_LEN];
    logic [15:0]     r_crc;
    logic [15:0]     r_got;
    logic [7:0]      r_decl;
    logic [7:0]      r_left;
    logic [3:0]      r_cnt;
    logic [3:0]      r_bpos;
    logic [63:0]     r_pack;
    logic [5:0]      r_n;
    logic [31:0]     r_frames;
    logic [31:0]     r_resync;
    logic [31:0]     r_badlen;
    logic [31:0]     r_badcrc;

    logic                               r_ovalid;
    logic [ccfd_pkg::OUT_DATA_W-1:0]    r_odata;
    logic                               r_okind;
    logic                               r_olast;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    rd_data;
    logic          out_free;
    logic          emit_now;
    logic          hdr_bad;
    logic [FW-1:0] needed;
    logic [FW-1:0] crc_end;
    logic [5:0]    chunks;
    logic [6:0]    slots_used;
    logic [7:0]    expect_chk;

    ccfd_ram #(.WIDTH(8), .DEPTH(ccfd_pkg::BUF_BYTES)) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign o_item_ready = (r_st == S_IDLE);
    assign we    = (r_st == S_IDLE) && i_item_valid && (i_item.op == ccfd_pkg::OP_PUSH)
                   && (r_fill != FW'(ccfd_pkg::BUF_BYTES));
    assign waddr = r_head + r_fill[AW-1:0];
    assign raddr = r_head + r_idx[AW-1:0];

    assign out_free   = !r_ovalid || i_ready;
    assign emit_now   = ((r_st == S_EMIT) || (r_st == S_STAT)) && out_free;
    assign expect_chk = r_h[2] ^ r_h[3] ^ ccfd_pkg::CHECK_XOR;
    assign hdr_bad    = (r_h[0] != i_cfg.sync_first) || (r_h[1] != i_cfg.sync_second)
                        || (r_h[4] != expect_chk);
    assign needed     = FW'(r_decl) + FW'(ccfd_pkg::HDR_LEN + ccfd_pkg::TRL_LEN);
    assign crc_end    = FW'(r_decl) + FW'(ccfd_pkg::HDR_LEN - 1);
    assign chunks     = (r_decl == 8'd0) ? 6'd1 : 6'((9'(r_decl) + 9'd7) >> 3);
    assign slots_used = 7'(r_n) + 7'(chunks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_wait   <= 1'b0;
            r_head   <= '0;
            r_fill   <= '0;
            r_n      <= '0;
            r_frames <= '0;
            r_resync <= '0;
            r_badlen <= '0;
            r_badcrc <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && !emit_now) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_n <= '0;
                        if (i_item.op == ccfd_pkg::OP_RESET) begin
                            r_fill <= '0;
                            r_st   <= S_STAT;
                        end else begin
                            if (we) begin
                                r_fill <= r_fill + FW'(1);
                            end
                            r_st <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx  <= '0;
                    r_wait <= 1'b0;
                    if (r_fill < FW'(ccfd_pkg::HDR_LEN)) begin
                        r_st <= S_STAT;
                    end else begin
                        r_st <= S_HDR;
                    end
                end
                S_HDR: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else begin
                        r_wait          <= 1'b0;
                        r_h[r_idx[2:0]] <= rd_data;
                        r_idx           <= r_idx + FW'(1);
                        if (r_idx == FW'(ccfd_pkg::HDR_LEN - 1)) begin
                            r_st <= S_EVAL;
                        end
                    end
                    r_decl <= r_h[2];
                end
                S_EVAL: begin
                    priority if (hdr_bad) begin
                        r_resync <= r_resync + 32'd1;
                        r_head   <= r_head + AW'(1);
                        r_fill   <= r_fill - FW'(1);
                        r_st     <= S_SCAN;
                    end else if (r_h[3] != 8'h00 || r_h[2] > i_cfg.max_payload) begin
                        r_badlen <= r_badlen + 32'd1;
                        r_resync <= r_resync + 32'd1;
                        r_head   <= r_head + AW'(1);
                        r_fill   <= r_fill - FW'(1);
                        r_st     <= S_SCAN;
                    end else if (r_fill < needed) begin
                        r_st <= S_STAT;
                    end else begin
                        r_decl <= r_h[2];
                        r_crc  <= ccfd_pkg::CRC_INIT;
                        r_idx  <= FW'(2);
                        r_wait <= 1'b0;
                        r_st   <= S_CRC;
                    end
                end
                S_CRC: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else begin
                        r_wait <= 1'b0;
                        r_idx  <= r_idx + FW'(1);
                        if (r_idx <= crc_end) begin
                            r_crc <= ccfd_pkg::crc_byte(r_crc, rd_data);
                        end else if (r_idx == crc_end + FW'(1)) begin
                            r_got[7:0] <= rd_data;
                        end else begin
                            r_got[15:8] <= rd_data;
                            r_st        <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    r_idx  <= FW'(ccfd_pkg::HDR_LEN);
                    r_wait <= 1'b0;
                    r_left <= r_decl;
                    r_cnt  <= (r_decl > 8'd8) ? 4'd8 : r_decl[3:0];
                    r_bpos <= '0;
                    r_pack <= '0;
                    priority if (r_crc != r_got) begin
                        r_badcrc <= r_badcrc + 32'd1;
                        r_resync <= r_resync + 32'd1;
                        r_head   <= r_head + AW'(1);
                        r_fill   <= r_fill - FW'(1);
                        r_st     <= S_SCAN;
                    end else if (slots_used > 7'(ccfd_pkg::RES_SLOTS - 1)) begin
                        // No room left before the status item: frame stays buffered.
                        r_st <= S_STAT;
                    end else begin
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_bpos == r_cnt) begin
                        r_st <= S_EMIT;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else begin
                        r_wait                      <= 1'b0;
                        r_pack[r_bpos[2:0]*8 +: 8]  <= rd_data;
                        r_bpos                      <= r_bpos + 4'd1;
                        r_idx                       <= r_idx + FW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= ccfd_pkg::KIND_CHUNK;
                        r_olast  <= 1'b0;
                        r_odata  <= {131'd0, (r_left <= 8'd8), r_pack, r_cnt};
                        r_n      <= r_n + 6'd1;
                        r_left   <= r_left - 8'(r_cnt);
                        r_cnt    <= (r_left - 8'(r_cnt) > 8'd8) ? 4'd8
                                    : 4'(r_left - 8'(r_cnt));
                        r_bpos   <= '0;
                        r_pack   <= '0;
                        if (r_left <= 8'd8) begin
                            r_head   <= r_head + needed[AW-1:0];
                            r_fill   <= r_fill - needed;
                            r_frames <= r_frames + 32'd1;
                            r_st     <= S_SCAN;
                        end else begin
                            r_st <= S_CHK;
                        end
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= ccfd_pkg::KIND_STATUS;
                        r_olast  <= 1'b1;
                        r_odata  <= {2'd0, r_badcrc, r_badlen, r_resync, r_frames,
                                     (r_fill != '0), 69'd0};
                        r_st     <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_kind  = r_okind;
    assign o_last  = r_olast;

endmodule
